// ----- hdl/llne_pkg.sv -----
// Shared constants, types and helper functions of the login name line editor.
// Depends on nothing; every other file of the block but llne_ram refers to it by scoped names.
package llne_pkg;

  // Sizing.
  localparam int unsigned NAME_DEPTH = 16;
  localparam int unsigned BLANK_RUN  = 37;

  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned NAME_LEN_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned PAR_W      = 2;

  localparam int unsigned CNT_W   = $clog2(NAME_DEPTH + 1);
  localparam int unsigned IDX_W   = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int unsigned MAX_RES = ((BLANK_RUN + 3) > (NAME_DEPTH + 2)) ?
                                    (BLANK_RUN + 3) : (NAME_DEPTH + 2);
  localparam int unsigned K_W     = $clog2(MAX_RES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY = 3'd5;

  // Parity modes.
  localparam logic [PAR_W-1:0] PAR_EVEN = 2'd1;
  localparam logic [PAR_W-1:0] PAR_ODD  = 2'd2;

  // Characters.
  localparam logic [CHAR_W-1:0] CH_NUL   = 7'd0;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'd13;
  localparam logic [CHAR_W-1:0] CH_SP    = 7'd32;
  localparam logic [CHAR_W-1:0] CH_HASH  = 7'd35;
  localparam logic [CHAR_W-1:0] CH_0     = 7'd48;
  localparam logic [CHAR_W-1:0] CH_9     = 7'd57;
  localparam logic [CHAR_W-1:0] CH_AT    = 7'd64;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'd65;
  localparam logic [CHAR_W-1:0] CH_UZ    = 7'd90;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'd97;
  localparam logic [CHAR_W-1:0] CH_LZ    = 7'd122;
  localparam logic [CHAR_W-1:0] CH_TILDE = 7'd126;
  localparam logic [CHAR_W-1:0] CH_DEL   = 7'd127;
  localparam logic [CHAR_W-1:0] CH_NAK   = 7'd21;
  localparam logic [CHAR_W-1:0] CH_EOT   = 7'd4;

  localparam logic [BYTE_W-1:0] PARITY_BIT = 8'h80;

  // Step status reported on every result.
  typedef enum logic [STAT_W-1:0] {
    STAT_EDIT     = 3'd0,
    STAT_COMPLETE = 3'd1,
    STAT_ABORT    = 3'd2,
    STAT_EOF      = 3'd3,
    STAT_IDLE     = 3'd4
  } stat_e;

  // Controller to datapath.
  typedef struct packed {
    logic           accept;
    logic           load;
    logic [K_W-1:0] k;
    logic [K_W-1:0] k_next;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_last;
  } sts_t;

  // Applies the selected echo parity to bit 7.
  function automatic logic [BYTE_W-1:0] add_parity(input logic [BYTE_W-1:0] b,
                                                   input logic [PAR_W-1:0] mode);
    logic [BYTE_W-1:0] r;
    r = b;
    if (mode == PAR_EVEN || mode == PAR_ODD) begin
      r[BYTE_W-1] = b[BYTE_W-1] | (^b[CHAR_W-1:0]);
    end
    if (mode == PAR_ODD) begin
      r = r ^ PARITY_BIT;
    end
    return r;
  endfunction

endpackage

// ----- hdl/llne_in_if.sv -----
// Input channel of the login name line editor: request type and received byte.
// Depends on llne_pkg for the field widths.
interface llne_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [llne_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- hdl/llne_out_if.sv -----
// Result channel of the login name line editor: echo byte, name character and status.
// Depends on llne_pkg for the field widths.
interface llne_out_if;
  logic                            valid;
  logic                            ready;
  logic [llne_pkg::BYTE_W-1:0]     echo_byte;
  logic                            echo_valid;
  logic [llne_pkg::CHAR_W-1:0]     name_char;
  logic                            name_char_valid;
  logic [llne_pkg::STAT_W-1:0]     status;
  logic [llne_pkg::NAME_LEN_W-1:0] name_length;
  logic                            saw_upper;
  logic                            saw_lower;
  logic                            saw_digit;
  logic                            ended_with_cr;
  logic                            prompt_request;
  logic                            last;

  modport source (output valid, output echo_byte, output echo_valid, output name_char,
                  output name_char_valid, output status, output name_length,
                  output saw_upper, output saw_lower, output saw_digit,
                  output ended_with_cr, output prompt_request, output last,
                  input ready);
  modport sink   (input valid, input echo_byte, input echo_valid, input name_char,
                  input name_char_valid, input status, input name_length,
                  input saw_upper, input saw_lower, input saw_digit,
                  input ended_with_cr, input prompt_request, input last,
                  output ready);
endinterface

// ----- hdl/llne_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module llne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/llne_ctrl.sv -----
// Controller of the login name line editor: takes an item, then sequences its results
// into the output register. Depends on llne_pkg.
module llne_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output llne_pkg::cmd_t  cmd_o,
  input  llne_pkg::sts_t  sts_i
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                     state_q, state_d;
  logic [llne_pkg::K_W-1:0]   k_q, k_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The output register takes the next result when it is empty or being emptied.
  assign load       = (state_q == S_RUN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = load || (out_valid_q && !out_ready_i);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          k_d     = '0;
        end
      end
      S_RUN: begin
        if (load) begin
          if (sts_i.is_last) begin
            state_d = S_IDLE;
          end else begin
            k_d = llne_pkg::K_W'(k_q + 1'b1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.load    = load;
  assign cmd_o.k       = k_q;
  assign cmd_o.k_next  = k_d;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load)
    else $error("result register overwritten while held");

  a_k_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (k_q < llne_pkg::K_W'(llne_pkg::MAX_RES)))
    else $error("result index ran past the longest sequence");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sts_i.is_last) |=> (in_ready_o && out_valid_o))
    else $error("final result did not return the controller to idle");

endmodule

// ----- hdl/llne_dp.sv -----
// Datapath of the login name line editor: configuration, edit state, name store,
// step decode and result generation. Depends on llne_pkg and llne_ram.
module llne_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  llne_pkg::cmd_t                      cmd_i,
  output llne_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [llne_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [llne_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                req_type_i,
  input  logic [llne_pkg::BYTE_W-1:0]         rx_byte_i,
  output logic [llne_pkg::BYTE_W-1:0]         echo_byte_o,
  output logic                                echo_valid_o,
  output logic [llne_pkg::CHAR_W-1:0]         name_char_o,
  output logic                                name_char_valid_o,
  output logic [llne_pkg::STAT_W-1:0]         status_o,
  output logic [llne_pkg::NAME_LEN_W-1:0]     name_length_o,
  output logic                                saw_upper_o,
  output logic                                saw_lower_o,
  output logic                                saw_digit_o,
  output logic                                ended_with_cr_o,
  output logic                                prompt_request_o,
  output logic                                last_o
);

  localparam int unsigned CW = llne_pkg::CHAR_W;
  localparam int unsigned BW = llne_pkg::BYTE_W;
  localparam int unsigned KW = llne_pkg::K_W;
  localparam int unsigned NW = llne_pkg::CNT_W;

  // Echo sequence chosen for a step.
  typedef enum logic [2:0] {
    PLAN_NONE,
    PLAN_RAW,
    PLAN_ERASE,
    PLAN_KILL_SLOW,
    PLAN_KILL_SHORT,
    PLAN_KILL_BLANK,
    PLAN_DONE
  } plan_e;

  // Configuration registers.
  logic [CW-1:0]                erase_q, kill_q, eof_q;
  logic                         ignore_q, fast_q;
  logic [llne_pkg::PAR_W-1:0]   parity_q;

  // Edit state and per-step registers.
  logic [NW-1:0]     count_q, count_d;
  logic              upper_q, upper_d, lower_q, lower_d, digit_q, digit_d;
  logic              accepting_q, accepting_d;
  llne_pkg::stat_e   stat_q, stat_d;
  logic              cr_q, cr_d, prm_q, prm_d;
  plan_e             plan_q, plan_d;
  logic [KW-1:0]     last_idx_q, last_idx_d;
  logic [BW-1:0]     cs_q;

  // Decode helpers.
  logic [CW-1:0]     c;
  logic              store;
  logic              dropped;
  logic              ram_we;
  logic [CW-1:0]     ram_rdata;

  // Result generation.
  logic [BW-1:0]     echo_raw;
  logic              echo_v;
  logic [CW-1:0]     nch;
  logic              nch_v;

  // Output register.
  logic [BW-1:0]                   echo_q;
  logic                            echo_v_q;
  logic [CW-1:0]                   nch_q;
  logic                            nch_v_q;
  logic [llne_pkg::STAT_W-1:0]     ostat_q;
  logic [llne_pkg::NAME_LEN_W-1:0] olen_q;
  logic                            oup_q, olow_q, odig_q, ocr_q, oprm_q, olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q  <= llne_pkg::CH_DEL;
      kill_q   <= llne_pkg::CH_NAK;
      eof_q    <= llne_pkg::CH_EOT;
      ignore_q <= 1'b0;
      fast_q   <= 1'b1;
      parity_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        llne_pkg::CFG_ERASE:  erase_q  <= cfg_data_i;
        llne_pkg::CFG_KILL:   kill_q   <= cfg_data_i;
        llne_pkg::CFG_EOF:    eof_q    <= cfg_data_i;
        llne_pkg::CFG_IGNORE: ignore_q <= cfg_data_i[0];
        llne_pkg::CFG_FAST:   fast_q   <= cfg_data_i[0];
        llne_pkg::CFG_PARITY: parity_q <= cfg_data_i[llne_pkg::PAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign c = rx_byte_i[CW-1:0];

  // Step decode, in the order the special characters take precedence.
  always_comb begin
    count_d     = count_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    digit_d     = digit_q;
    accepting_d = accepting_q;
    stat_d      = llne_pkg::STAT_EDIT;
    cr_d        = 1'b0;
    prm_d       = 1'b0;
    plan_d      = PLAN_NONE;
    store       = 1'b0;
    dropped     = 1'b0;
    priority if (!req_type_i) begin
      count_d     = '0;
      upper_d     = 1'b0;
      lower_d     = 1'b0;
      digit_d     = 1'b0;
      accepting_d = 1'b1;
    end else if (!accepting_q) begin
      stat_d = llne_pkg::STAT_IDLE;
    end else if (c == llne_pkg::CH_NUL) begin
      accepting_d = 1'b0;
      stat_d      = llne_pkg::STAT_ABORT;
    end else if (c == eof_q) begin
      accepting_d = 1'b0;
      stat_d      = llne_pkg::STAT_EOF;
    end else if (c == llne_pkg::CH_CR || c == llne_pkg::CH_LF ||
                 count_q >= NW'(llne_pkg::NAME_DEPTH)) begin
      plan_d      = PLAN_DONE;
      cr_d        = (c == llne_pkg::CH_CR);
      accepting_d = 1'b0;
      stat_d      = llne_pkg::STAT_COMPLETE;
    end else if (c >= llne_pkg::CH_LA && c <= llne_pkg::CH_LZ) begin
      lower_d = 1'b1;
      store   = 1'b1;
    end else if (c >= llne_pkg::CH_UA && c <= llne_pkg::CH_UZ) begin
      upper_d = 1'b1;
      store   = 1'b1;
    end else if (c == erase_q || c == llne_pkg::CH_HASH || c == llne_pkg::CH_BS) begin
      if (count_q != '0) begin
        count_d = NW'(count_q - 1'b1);
        plan_d  = fast_q ? PLAN_ERASE : PLAN_RAW;
      end
    end else if (c == kill_q || c == llne_pkg::CH_AT) begin
      priority if (!fast_q) begin
        plan_d = PLAN_KILL_SLOW;
      end else if (count_q != '0) begin
        plan_d = PLAN_KILL_BLANK;
      end else begin
        plan_d = PLAN_KILL_SHORT;
      end
      count_d = '0;
      prm_d   = 1'b1;
    end else begin
      if (c >= llne_pkg::CH_0 && c <= llne_pkg::CH_9) begin
        digit_d = 1'b1;
      end
      store = 1'b1;
    end
    dropped = ignore_q && (c <= llne_pkg::CH_SP || c > llne_pkg::CH_TILDE);
    // The full-buffer case completes above, so a stored character always fits.
    if (store && !dropped) begin
      count_d = NW'(count_q + 1'b1);
      plan_d  = PLAN_RAW;
    end
  end

  always_comb begin
    unique case (plan_d)
      PLAN_NONE, PLAN_RAW: last_idx_d = '0;
      PLAN_ERASE, PLAN_KILL_SLOW: last_idx_d = KW'(2);
      PLAN_KILL_SHORT: last_idx_d = KW'(1);
      PLAN_KILL_BLANK: last_idx_d = KW'(llne_pkg::BLANK_RUN + 2);
      PLAN_DONE: last_idx_d = KW'(KW'(count_q) + KW'(1));
      default: last_idx_d = '0;
    endcase
  end

  assign ram_we = cmd_i.accept && req_type_i && accepting_q && store && !dropped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      upper_q     <= 1'b0;
      lower_q     <= 1'b0;
      digit_q     <= 1'b0;
      accepting_q <= 1'b1;
      stat_q      <= llne_pkg::STAT_IDLE;
      cr_q        <= 1'b0;
      prm_q       <= 1'b0;
      plan_q      <= PLAN_NONE;
      last_idx_q  <= '0;
    end else if (cmd_i.accept) begin
      count_q     <= count_d;
      upper_q     <= upper_d;
      lower_q     <= lower_d;
      digit_q     <= digit_d;
      accepting_q <= accepting_d;
      stat_q      <= stat_d;
      cr_q        <= cr_d;
      prm_q       <= prm_d;
      plan_q      <= plan_d;
      last_idx_q  <= last_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cs_q <= rx_byte_i;
    end
  end

  // The read address follows the next result index, so the registered read data
  // lines up with the result index of the following cycle.
  llne_ram #(
    .WIDTH (CW),
    .DEPTH (llne_pkg::NAME_DEPTH)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (llne_pkg::IDX_W'(count_q)),
    .wdata_i (c),
    .raddr_i (llne_pkg::IDX_W'(cmd_i.k_next - KW'(2))),
    .rdata_o (ram_rdata)
  );

  assign sts_o.is_last = (cmd_i.k == last_idx_q);

  always_comb begin
    echo_raw = '0;
    echo_v   = 1'b0;
    nch      = '0;
    nch_v    = 1'b0;
    unique case (plan_q)
      PLAN_NONE: ;
      PLAN_RAW: begin
        echo_v   = 1'b1;
        echo_raw = cs_q;
      end
      PLAN_ERASE: begin
        echo_v   = 1'b1;
        echo_raw = {1'b0, (cmd_i.k == KW'(1)) ? llne_pkg::CH_SP : llne_pkg::CH_BS};
      end
      PLAN_KILL_SLOW: begin
        echo_v = 1'b1;
        priority if (cmd_i.k == '0) begin
          echo_raw = cs_q;
        end else if (cmd_i.k == KW'(1)) begin
          echo_raw = {1'b0, llne_pkg::CH_CR};
        end else begin
          echo_raw = {1'b0, llne_pkg::CH_LF};
        end
      end
      PLAN_KILL_SHORT: begin
        echo_v   = 1'b1;
        echo_raw = (cmd_i.k == '0) ? cs_q : {1'b0, llne_pkg::CH_CR};
      end
      PLAN_KILL_BLANK: begin
        echo_v = 1'b1;
        priority if (cmd_i.k == '0) begin
          echo_raw = cs_q;
        end else if (cmd_i.k == KW'(1) || cmd_i.k == last_idx_q) begin
          echo_raw = {1'b0, llne_pkg::CH_CR};
        end else begin
          echo_raw = {1'b0, llne_pkg::CH_SP};
        end
      end
      PLAN_DONE: begin
        priority if (cmd_i.k == '0) begin
          echo_v   = 1'b1;
          echo_raw = {1'b0, llne_pkg::CH_CR};
        end else if (cmd_i.k == KW'(1)) begin
          echo_v   = 1'b1;
          echo_raw = {1'b0, llne_pkg::CH_LF};
        end else begin
          nch_v = 1'b1;
          nch   = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      echo_q   <= echo_v ? llne_pkg::add_parity(echo_raw, parity_q) : '0;
      echo_v_q <= echo_v;
      nch_q    <= nch;
      nch_v_q  <= nch_v;
      ostat_q  <= stat_q;
      olen_q   <= llne_pkg::NAME_LEN_W'(count_q);
      oup_q    <= upper_q;
      olow_q   <= lower_q;
      odig_q   <= digit_q;
      ocr_q    <= cr_q;
      oprm_q   <= prm_q;
      olast_q  <= sts_o.is_last;
    end
  end

  assign echo_byte_o       = echo_q;
  assign echo_valid_o      = echo_v_q;
  assign name_char_o       = nch_q;
  assign name_char_valid_o = nch_v_q;
  assign status_o          = ostat_q;
  assign name_length_o     = olen_q;
  assign saw_upper_o       = oup_q;
  assign saw_lower_o       = olow_q;
  assign saw_digit_o       = odig_q;
  assign ended_with_cr_o   = ocr_q;
  assign prompt_request_o  = oprm_q;
  assign last_o            = olast_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(llne_pkg::NAME_DEPTH))
    else $error("name length beyond the store depth");

  a_edit_needs_accepting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_q == llne_pkg::STAT_EDIT) |-> accepting_q)
    else $error("editing status reported on a closed line");

  a_done_reads_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && plan_q == PLAN_DONE && cmd_i.k > KW'(1)) |->
    (KW'(cmd_i.k - KW'(2)) < KW'(count_q)))
    else $error("name read beyond the stored characters");

endmodule

// ----- hdl/login_name_line_editor.sv -----
// Login name line editor. An item (start request or received byte) is taken only
// while the result sequencer is idle; it then produces between 1 and 40 results, one
// per clock while the result sink is ready, and the sequencer stays busy until the
// final result is loaded. The sequencer fills a single output register one result at
// a time and reads the name store one entry per cycle while the sink is ready. The
// next item may be taken while the final result still waits. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while
// idle, as the block itself does not enforce this.
module login_name_line_editor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  llne_in_if.sink                             in_i,
  llne_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [llne_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [llne_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  llne_pkg::cmd_t cmd;
  llne_pkg::sts_t sts;

  llne_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  llne_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (in_i.req_type),
    .rx_byte_i         (in_i.rx_byte),
    .echo_byte_o       (out_o.echo_byte),
    .echo_valid_o      (out_o.echo_valid),
    .name_char_o       (out_o.name_char),
    .name_char_valid_o (out_o.name_char_valid),
    .status_o          (out_o.status),
    .name_length_o     (out_o.name_length),
    .saw_upper_o       (out_o.saw_upper),
    .saw_lower_o       (out_o.saw_lower),
    .saw_digit_o       (out_o.saw_digit),
    .ended_with_cr_o   (out_o.ended_with_cr),
    .prompt_request_o  (out_o.prompt_request),
    .last_o            (out_o.last)
  );

endmodule
